### sv/ltdt_pkg.sv
// Package for the load throttle delay tracker: widths, constants, the
// controller-to-datapath command struct and small helper functions.
// No dependencies.
package ltdt_pkg;

  // Field widths.
  localparam int TIME_W   = 48;
  localparam int DELAY_W  = 11;
  localparam int METRIC_W = 2;
  localparam int QUEUE_W  = 16;
  localparam int AVG_W    = 24;
  localparam int RETRY_W  = 32;
  localparam int ELEM_W   = 16;
  localparam int BYTES_W  = 32;
  localparam int DUR_W    = 32;

  // Metric slots.
  localparam int NUM_METRICS = 3;
  localparam logic [METRIC_W-1:0] M_QUEUE = 2'd0;
  localparam logic [METRIC_W-1:0] M_RETRY = 2'd1;
  localparam logic [METRIC_W-1:0] M_NODE  = 2'd2;

  // Configuration register indexes (taken from paddr[2]).
  localparam logic REG_ELEM_SPLIT = 1'b0;
  localparam logic REG_BYTE_SPLIT = 1'b1;
  localparam logic [ELEM_W-1:0]  ELEM_SPLIT_RST = 16'd1000;
  localparam logic [BYTES_W-1:0] BYTE_SPLIT_RST = 32'd8192;

  // Backoff constants.
  localparam logic [DELAY_W-1:0] DELAY_CAP = 11'd1024;
  // queue / 10 as (queue * 52429) >> 19, exact over 16 bits.
  localparam logic [15:0] QUEUE_RECIP = 16'd52429;
  // retry / 100 as (retry * 167773) >> 24, exact below 199729.
  localparam logic [17:0] RETRY_RECIP = 18'd167773;
  // From this retry value on, the retry backoff is capped.
  localparam logic [RETRY_W-1:0] RETRY_CAP_MIN = 32'd100400;
  // x / 100 as (x * 41) >> 12, exact for x below 1000.
  localparam logic [15:0] HUNDRED_RECIP = 16'd41;
  // Number of multiples of the split size that are compared.
  localparam int NODE_STEPS = 12;
  localparam int STEP_W     = 4;

  // One-cycle commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture an input beat
    logic mul;    // run the reciprocal and duration multipliers
    logic back;   // form queue and retry backoffs
    logic step;   // one compare-and-add step of the node size unit
    logic apply;  // update the metric table
    logic pick;   // select the winner into the output register
  } cmd_t;

  // Saturating add of a duration to a time stamp.
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
                                                input logic [DUR_W-1:0] d);
    logic [TIME_W:0] s;
    s = {1'b0, t} + {{(TIME_W + 1 - DUR_W){1'b0}}, d};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  // Node backoff from a quotient already capped at twelve.
  function automatic logic [DELAY_W-1:0] node_backoff(input logic [STEP_W-1:0] x);
    logic [DELAY_W-1:0] d;
    if (x < 4'd2) begin
      d = '0;
    end else if (x < 4'd12) begin
      d = DELAY_W'(1) << (x - 4'd2);
    end else begin
      d = DELAY_CAP;
    end
    return d;
  endfunction

endpackage

### sv/ltdt_ctrl.sv
// Controller of the load throttle delay tracker: sequences one item through
// the datapath and owns the handshake flags. Depends on ltdt_pkg.
module ltdt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output ltdt_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_BACK,
    S_STEP,
    S_APPLY,
    S_PICK
  } state_t;

  state_t state_r, state_nxt;
  logic [ltdt_pkg::STEP_W-1:0] step_cnt_r, step_cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic pick_ok;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  // The output register can take a new result when empty or being drained.
  assign pick_ok    = !out_valid_r || out_tready;

  // Next state, step count and command decode.
  always_comb begin
    state_nxt    = state_r;
    step_cnt_nxt = step_cnt_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_BACK;
      end
      S_BACK: begin
        cmd.back     = 1'b1;
        step_cnt_nxt = '0;
        state_nxt    = S_STEP;
      end
      S_STEP: begin
        cmd.step     = 1'b1;
        step_cnt_nxt = step_cnt_r + 1'b1;
        if (step_cnt_r == ltdt_pkg::STEP_W'(ltdt_pkg::NODE_STEPS - 1)) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        if (pick_ok) begin
          cmd.pick  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = (out_valid_r && !out_tready) || cmd.pick;
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_cnt_r  <= step_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### sv/ltdt_dp.sv
// Datapath of the load throttle delay tracker: input capture, backoff
// arithmetic, node size step unit, metric table and output register.
// Depends on ltdt_pkg; driven by commands from ltdt_ctrl.
module ltdt_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ltdt_pkg::cmd_t                  cmd,
  input  logic [ltdt_pkg::TIME_W-1:0]     now_ms,
  input  logic                            load_valid,
  input  logic [ltdt_pkg::QUEUE_W-1:0]    queue_size,
  input  logic [ltdt_pkg::AVG_W-1:0]      split_time_avg,
  input  logic [ltdt_pkg::RETRY_W-1:0]    retry_ms,
  input  logic                            size_valid,
  input  logic [ltdt_pkg::ELEM_W-1:0]     node_elements,
  input  logic [ltdt_pkg::BYTES_W-1:0]    node_bytes,
  input  logic [ltdt_pkg::ELEM_W-1:0]     element_split_size,
  input  logic [ltdt_pkg::BYTES_W-1:0]    byte_split_size,
  output logic [ltdt_pkg::DELAY_W-1:0]    current_delay,
  output logic [ltdt_pkg::METRIC_W-1:0]   winning_metric
);

  localparam int ACC_E_W = ltdt_pkg::ELEM_W + 4;
  localparam int ACC_B_W = ltdt_pkg::BYTES_W + 4;

  // Captured item.
  logic [ltdt_pkg::TIME_W-1:0]  now_r;
  logic                         load_v_r, size_v_r;
  logic [ltdt_pkg::QUEUE_W-1:0] queue_r;
  logic [ltdt_pkg::AVG_W-1:0]   avg_r;
  logic [ltdt_pkg::RETRY_W-1:0] retry_r;
  logic [ltdt_pkg::ELEM_W-1:0]  nelem_r;
  logic [ltdt_pkg::BYTES_W-1:0] nbytes_r;

  // Multiplier results.
  logic [31:0] qmul_r;
  logic [39:0] prod0_r;
  logic [34:0] rmul_r;
  logic        retry_big_r;

  // Backoff results.
  logic [ltdt_pkg::DELAY_W-1:0] d0_r, d0_nxt, d1_r, d1_nxt;
  logic [ltdt_pkg::DUR_W-1:0]   dur0_r, dur0_nxt;

  // Node size step unit.
  logic [ACC_E_W-1:0] acc_e_r;
  logic [ACC_B_W-1:0] acc_b_r;
  logic [ltdt_pkg::STEP_W-1:0] cnt_e_r, cnt_b_r;
  logic [ltdt_pkg::ELEM_W-1:0]  es_eff;
  logic [ltdt_pkg::BYTES_W-1:0] bs_eff;

  // Metric table.
  logic [ltdt_pkg::DELAY_W-1:0] delay_r  [ltdt_pkg::NUM_METRICS];
  logic [ltdt_pkg::TIME_W-1:0]  expiry_r [ltdt_pkg::NUM_METRICS];

  // Output register.
  logic [ltdt_pkg::DELAY_W-1:0]  cur_delay_r;
  logic [ltdt_pkg::METRIC_W-1:0] win_r;

  logic [12:0] q;
  logic [10:0] r;
  logic [9:0]  r_off;
  logic [15:0] kmul;
  logic [ltdt_pkg::DELAY_W-1:0] de, db, dn;
  logic [ltdt_pkg::DELAY_W-1:0] best;
  logic [ltdt_pkg::METRIC_W-1:0] win;

  // A split size of zero counts as one.
  assign es_eff = (element_split_size == '0) ? ltdt_pkg::ELEM_W'(1) : element_split_size;
  assign bs_eff = (byte_split_size == '0) ? ltdt_pkg::BYTES_W'(1) : byte_split_size;

  // Queue and retry backoffs from the registered products.
  always_comb begin
    q     = qmul_r[31:19];
    r     = rmul_r[34:24];
    r_off = 10'(r - 11'd4);
    kmul  = 16'(r_off) * ltdt_pkg::HUNDRED_RECIP;
    if (q < 13'd5) begin
      d0_nxt = '0;
    end else if (q < 13'd14) begin
      d0_nxt = ltdt_pkg::DELAY_W'(1) << 4'(q - 13'd4);
    end else begin
      d0_nxt = ltdt_pkg::DELAY_CAP;
    end
    dur0_nxt = ltdt_pkg::DUR_W'((41'(prod0_r) + 41'd511) >> 9);
    if (retry_big_r) begin
      d1_nxt = ltdt_pkg::DELAY_CAP;
    end else if (r < 11'd5) begin
      d1_nxt = '0;
    end else begin
      d1_nxt = ltdt_pkg::DELAY_W'(1) << kmul[15:12];
    end
  end

  // Node delay and winner selection.
  always_comb begin
    de   = ltdt_pkg::node_backoff(cnt_e_r);
    db   = ltdt_pkg::node_backoff(cnt_b_r);
    dn   = (de > db) ? de : db;
    best = '0;
    win  = ltdt_pkg::M_QUEUE;
    for (int i = 0; i < ltdt_pkg::NUM_METRICS; i++) begin
      if (expiry_r[i] > now_r && best < delay_r[i]) begin
        best = delay_r[i];
        win  = ltdt_pkg::METRIC_W'(i);
      end
    end
  end

  // Input capture, multipliers, backoffs and step unit.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r    <= now_ms;
      load_v_r <= load_valid;
      size_v_r <= size_valid;
      queue_r  <= queue_size;
      avg_r    <= split_time_avg;
      retry_r  <= retry_ms;
      nelem_r  <= node_elements;
      nbytes_r <= node_bytes;
    end
    if (cmd.mul) begin
      qmul_r      <= 32'(queue_r) * 32'(ltdt_pkg::QUEUE_RECIP);
      prod0_r     <= 40'(avg_r) * 40'(queue_r);
      rmul_r      <= 35'(retry_r[16:0]) * 35'(ltdt_pkg::RETRY_RECIP);
      retry_big_r <= (retry_r >= ltdt_pkg::RETRY_CAP_MIN);
    end
    if (cmd.back) begin
      d0_r    <= d0_nxt;
      dur0_r  <= dur0_nxt;
      d1_r    <= d1_nxt;
      acc_e_r <= ACC_E_W'(es_eff);
      acc_b_r <= ACC_B_W'(bs_eff);
      cnt_e_r <= '0;
      cnt_b_r <= '0;
    end
    // Step j compares the size against j times the split size.
    if (cmd.step) begin
      if (ACC_E_W'(nelem_r) >= acc_e_r) cnt_e_r <= cnt_e_r + 1'b1;
      if (ACC_B_W'(nbytes_r) >= acc_b_r) cnt_b_r <= cnt_b_r + 1'b1;
      acc_e_r <= acc_e_r + ACC_E_W'(es_eff);
      acc_b_r <= acc_b_r + ACC_B_W'(bs_eff);
    end
    if (cmd.pick) begin
      cur_delay_r <= best;
      win_r       <= win;
    end
  end

  // Metric table update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ltdt_pkg::NUM_METRICS; i++) begin
        delay_r[i]  <= '0;
        expiry_r[i] <= '0;
      end
    end else if (cmd.apply) begin
      if (load_v_r) begin
        delay_r[ltdt_pkg::M_QUEUE]  <= d0_r;
        expiry_r[ltdt_pkg::M_QUEUE] <= ltdt_pkg::sat_add(now_r, dur0_r);
        delay_r[ltdt_pkg::M_RETRY]  <= d1_r;
        expiry_r[ltdt_pkg::M_RETRY] <= ltdt_pkg::sat_add(now_r,
                                          ltdt_pkg::DUR_W'({d1_r, 1'b0}));
      end
      if (size_v_r && (expiry_r[ltdt_pkg::M_NODE] < now_r ||
                       delay_r[ltdt_pkg::M_NODE] < dn)) begin
        delay_r[ltdt_pkg::M_NODE]  <= dn;
        expiry_r[ltdt_pkg::M_NODE] <= ltdt_pkg::sat_add(now_r,
                                         ltdt_pkg::DUR_W'({dn, 1'b0}));
      end
    end
  end

  assign current_delay  = cur_delay_r;
  assign winning_metric = win_r;

endmodule

### sv/load_throttle_delay_tracker_unit.sv
// Top level of the load throttle delay tracker: stream ports, APB register
// file and assertions. Depends on ltdt_pkg, ltdt_ctrl and ltdt_dp.
//
// Usage: each input beat carries the current time and optional load and node
// size reports (flags in in_tuser). Every beat yields exactly one output beat
// with the largest unexpired metric delay and the metric that gives it.
// An item passes, from acceptance to the next possible acceptance, through the
// accept cycle, the multiplier stage, the backoff stage, twelve compare-and-add
// steps of the node size unit (one multiple of the split size per step), the
// table update and the winner selection, which loads the output register. The
// output register holds a finished result while the receiver stalls and the
// next beat may be accepted meanwhile; a second result waits in the select
// stage until the register drains.
// Reset clears all metric delays and expiries, loads element_split_size with
// 1000 and byte_split_size with 8192, and empties the output register.
// Registers: element_split_size at address 0, byte_split_size at address 4;
// write them only while no beat is in flight.
module load_throttle_delay_tracker_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // now_ms[47:0], queue_size[63:48], split_time_avg[87:64], retry_ms[119:88],
  // node_elements[135:120], node_bytes[167:136]
  input  logic [167:0] in_tdata,
  // load_valid[0], size_valid[1]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // current_delay[10:0], winning_metric[12:11], zero[15:13]
  output logic [15:0]  out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [ltdt_pkg::ELEM_W-1:0]  elem_split_r;
  logic [ltdt_pkg::BYTES_W-1:0] byte_split_r;
  logic                         cfg_wr;
  ltdt_pkg::cmd_t               cmd;
  logic [ltdt_pkg::DELAY_W-1:0]  cur_delay;
  logic [ltdt_pkg::METRIC_W-1:0] win_metric;

  // Register file.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_split_r <= ltdt_pkg::ELEM_SPLIT_RST;
      byte_split_r <= ltdt_pkg::BYTE_SPLIT_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == ltdt_pkg::REG_ELEM_SPLIT) begin
        elem_split_r <= cfg_pwdata[ltdt_pkg::ELEM_W-1:0];
      end else begin
        byte_split_r <= cfg_pwdata;
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == ltdt_pkg::REG_BYTE_SPLIT) ? byte_split_r
                                                                 : 32'(elem_split_r);

  ltdt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  ltdt_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .now_ms             (in_tdata[47:0]),
    .load_valid         (in_tuser[0]),
    .queue_size         (in_tdata[63:48]),
    .split_time_avg     (in_tdata[87:64]),
    .retry_ms           (in_tdata[119:88]),
    .size_valid         (in_tuser[1]),
    .node_elements      (in_tdata[135:120]),
    .node_bytes         (in_tdata[167:136]),
    .element_split_size (elem_split_r),
    .byte_split_size    (byte_split_r),
    .current_delay      (cur_delay),
    .winning_metric     (win_metric)
  );

  assign out_tdata = {3'b000, win_metric, cur_delay};

  // The delay never exceeds the backoff cap.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[10:0] <= ltdt_pkg::DELAY_CAP)
    else $error("current_delay above cap");

  // No delay means the winning metric reads as the queue slot.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[10:0] == 11'd0) |-> out_tdata[12:11] == ltdt_pkg::M_QUEUE)
    else $error("winning_metric set with zero delay");

  // Metric index stays within the table.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[12:11] != 2'd3)
    else $error("winning_metric out of range");

  // An accepted beat keeps the controller busy in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("controller did not leave idle");

endmodule
